[sv/eats_pkg.sv]
// Shared types and constants for the elliptic arc segmenter.
`default_nettype none
package eats_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int STEP_TICKS        = 30 * 64;
  localparam int FULL_TURN         = 360 * 64;
  localparam int QUARTER_TURN      = 90 * 64;
  localparam int MAX_SEGMENTS      = 12;
  localparam logic [15:0] POOL_SIZE_RST = 16'd4096;
  localparam logic [15:0] DEPTH_RST     = 16'hFFFF;
  localparam logic [26:0] RAD_SCALE     = 27'd74961321;
  localparam logic signed [17:0] X_SEED = 18'sd19899;
  localparam logic [2:0] ADDR_POOL_SIZE = 3'd0;

  localparam logic [30:0] ATAN_Q30 [0:23] = '{
    31'd843314857, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARC, ST_RED, ST_ROT, ST_MUL, ST_SUM, ST_STEP, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic take;
    logic t_load;
    logic red;
    logic prep;
    logic rot;
    logic mul;
    logic sum;
    logic step;
    logic adv;
  } cmd_t;

  typedef struct packed {
    logic restart_req;
    logic pool_full;
    logic rem_zero;
    logic red_ok;
    logic rot_last;
    logic first;
  } sts_t;

endpackage
`default_nettype wire

[sv/eats_ctrl.sv]
// Sequencer for arc requests, angle reduction, CORDIC and segment output.
`default_nettype none
module eats_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire eats_pkg::sts_t sts,
  output eats_pkg::cmd_t     cmd
);
  import eats_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ARC;
        end
      end
      ST_ARC: begin
        if (sts.restart_req) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.pool_full) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.take = 1'b1;
          if (sts.rem_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.t_load = 1'b1;
            state_nxt  = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (sts.red_ok) begin
          cmd.prep  = 1'b1;
          state_nxt = ST_ROT;
        end else begin
          cmd.red = 1'b1;
        end
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (sts.rot_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.first ? ST_STEP : ST_OUT;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_RED;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.adv   = 1'b1;
          state_nxt = sts.rem_zero ? ST_IDLE : ST_STEP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/eats_dp.sv]
// Datapath: request registers, depth pool, angle reduction, CORDIC, point math.
`default_nettype none
module eats_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire eats_pkg::cmd_t      cmd,
  output eats_pkg::sts_t           sts,
  input  wire logic                cfg_wr,
  input  wire logic [15:0]         cfg_data,
  output logic [15:0]              pool_size,
  input  wire logic                in_req_type,
  input  wire logic signed [15:0]  in_box_x,
  input  wire logic signed [15:0]  in_box_y,
  input  wire logic [14:0]         in_box_width,
  input  wire logic [14:0]         in_box_height,
  input  wire logic signed [16:0]  in_start_angle,
  input  wire logic signed [16:0]  in_extent_angle,
  input  wire logic [15:0]         in_pen_color,
  output logic signed [16:0]       out_seg_x_start,
  output logic signed [16:0]       out_seg_y_start,
  output logic signed [16:0]       out_seg_x_end,
  output logic signed [16:0]       out_seg_y_end,
  output logic [15:0]              out_seg_color,
  output logic [15:0]              out_seg_depth,
  output logic                     out_seg_last
);
  import eats_pkg::*;

  logic [15:0] pool_size_r, pool_used_r, depth_r;
  logic        req_r, dir_neg_r, first_r;
  logic signed [15:0] bx_r, by_r;
  logic [14:0] w_r, h_r;
  logic [15:0] color_r;
  logic signed [17:0] cur_r, t_r;
  logic [14:0] rem_r;
  logic [3:0]  n_r;
  logic [1:0]  q_r;
  logic signed [32:0] z_r;
  logic signed [17:0] x_r, y_r;
  logic [4:0]  i_r;
  logic signed [31:0] px_prod_r, py_prod_r;
  logic signed [16:0] x1_r, y1_r, x2_r, y2_r;

  // request decode
  logic [16:0] ext_abs;
  logic [14:0] ext_clamp;
  always_comb begin
    ext_abs   = in_extent_angle[16] ? 17'(-in_extent_angle) : in_extent_angle;
    ext_clamp = (ext_abs > 17'(FULL_TURN)) ? 15'(FULL_TURN) : ext_abs[14:0];
  end

  // next step of the arc
  logic        short_step;
  logic [14:0] step_len;
  logic signed [17:0] cur_nxt;
  always_comb begin
    short_step = (n_r == 4'(MAX_SEGMENTS - 1)) || (rem_r <= 15'(STEP_TICKS));
    step_len   = short_step ? rem_r : 15'(STEP_TICKS);
    cur_nxt    = dir_neg_r ? cur_r - $signed({3'b000, step_len})
                           : cur_r + $signed({3'b000, step_len});
  end

  // quadrant split and radian conversion
  logic [1:0]  q_c;
  logic [12:0] r_c;
  logic [39:0] rad_prod;
  always_comb begin
    if (t_r >= 18'sd17280)      q_c = 2'd3;
    else if (t_r >= 18'sd11520) q_c = 2'd2;
    else if (t_r >= 18'sd5760)  q_c = 2'd1;
    else                        q_c = 2'd0;
    r_c      = 13'(t_r - 18'($signed({1'b0, q_c}) * QUARTER_TURN));
    rad_prod = 40'(r_c) * 40'(RAD_SCALE) + 40'd128;
  end

  // saturation and quadrant mapping
  logic signed [15:0] xs, ys, cos_c, sin_c;
  always_comb begin
    xs = (x_r > 18'sd32767) ? 16'sd32767 : (x_r < -18'sd32767) ? -16'sd32767 : x_r[15:0];
    ys = (y_r > 18'sd32767) ? 16'sd32767 : (y_r < -18'sd32767) ? -16'sd32767 : y_r[15:0];
    case (q_r)
      2'd0: begin cos_c = xs;  sin_c = ys;  end
      2'd1: begin cos_c = -ys; sin_c = xs;  end
      2'd2: begin cos_c = -xs; sin_c = -ys; end
      default: begin cos_c = ys; sin_c = -xs; end
    endcase
  end

  // point sums, truncated toward zero
  logic signed [17:0] bsx, bsy;
  logic signed [33:0] sx, sy;
  logic signed [16:0] px_c, py_c;
  always_comb begin
    bsx = $signed({bx_r[15], bx_r, 1'b0}) + $signed({3'b000, w_r});
    bsy = $signed({by_r[15], by_r, 1'b0}) + $signed({3'b000, h_r});
    sx  = $signed({bsx[17], bsx, 15'd0}) + 34'(px_prod_r);
    sy  = $signed({bsy[17], bsy, 15'd0}) - 34'(py_prod_r);
    if (sx < 0) sx = sx + 34'sd65535;
    if (sy < 0) sy = sy + 34'sd65535;
    px_c = sx[32:16];
    py_c = sy[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      pool_used_r <= '0;
      depth_r     <= DEPTH_RST;
    end else begin
      if (cfg_wr) pool_size_r <= cfg_data;
      if (cmd.restart) begin
        pool_used_r <= '0;
        depth_r     <= DEPTH_RST;
      end else if (cmd.take) begin
        pool_used_r <= pool_used_r + 16'd1;
        depth_r     <= depth_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req_type;
      bx_r      <= in_box_x;
      by_r      <= in_box_y;
      w_r       <= in_box_width;
      h_r       <= in_box_height;
      color_r   <= in_pen_color;
      cur_r     <= 18'(in_start_angle);
      dir_neg_r <= in_extent_angle[16];
      rem_r     <= ext_clamp;
      n_r       <= '0;
      first_r   <= 1'b1;
    end
    if (cmd.t_load) t_r <= cur_r;
    if (cmd.step) begin
      cur_r <= cur_nxt;
      t_r   <= cur_nxt;
      rem_r <= short_step ? 15'd0 : rem_r - 15'(STEP_TICKS);
      n_r   <= n_r + 4'd1;
    end
    if (cmd.red) begin
      t_r <= (t_r < 0) ? t_r + 18'(FULL_TURN) : t_r - 18'(FULL_TURN);
    end
    if (cmd.prep) begin
      q_r <= q_c;
      z_r <= $signed({1'b0, rad_prod[39:8]});
      x_r <= X_SEED;
      y_r <= '0;
      i_r <= '0;
    end
    if (cmd.rot) begin
      if (!z_r[32]) begin
        x_r <= x_r - (y_r >>> i_r);
        y_r <= y_r + (x_r >>> i_r);
        z_r <= z_r - $signed({2'b00, ATAN_Q30[i_r]});
      end else begin
        x_r <= x_r + (y_r >>> i_r);
        y_r <= y_r - (x_r >>> i_r);
        z_r <= z_r + $signed({2'b00, ATAN_Q30[i_r]});
      end
      i_r <= i_r + 5'd1;
    end
    if (cmd.mul) begin
      px_prod_r <= $signed({1'b0, w_r}) * cos_c;
      py_prod_r <= $signed({1'b0, h_r}) * sin_c;
    end
    if (cmd.sum) begin
      x2_r <= px_c;
      y2_r <= py_c;
      if (first_r) begin
        x1_r    <= px_c;
        y1_r    <= py_c;
        first_r <= 1'b0;
      end
    end
    if (cmd.adv) begin
      x1_r <= x2_r;
      y1_r <= y2_r;
    end
  end

  always_comb begin
    sts.restart_req = req_r;
    sts.pool_full   = pool_used_r >= pool_size_r;
    sts.rem_zero    = rem_r == 15'd0;
    sts.red_ok      = (t_r >= 0) && (t_r < 18'(FULL_TURN));
    sts.rot_last    = i_r == 5'(CORDIC_ITERATIONS - 1);
    sts.first       = first_r;
  end

  assign pool_size       = pool_size_r;
  assign out_seg_x_start = x1_r;
  assign out_seg_y_start = y1_r;
  assign out_seg_x_end   = x2_r;
  assign out_seg_y_end   = y2_r;
  assign out_seg_color   = color_r;
  assign out_seg_depth   = depth_r;
  assign out_seg_last    = rem_r == 15'd0;

endmodule
`default_nettype wire

[sv/elliptic_arc_to_segments.sv]
// Top level of the elliptic arc to line segment converter.
//
//  channel | direction | handshake             | content
//  in_     | input     | in_valid / in_ready   | arc request or frame restart
//  out_    | output    | out_valid / out_ready | one line segment per item
//  cfg_    | input     | APB psel/penable      | pool_size at address 0
//
// Each arc point runs any angle reduction steps needed, one radian conversion,
// 16 CORDIC iterations through one shared rotator, one multiply and one
// sum step; each segment adds a step and an output state. An arc of
// 12 segments takes 13 points. One item is in work at a time; in_ready is
// high only when idle. A stalled output holds the segment until taken.
// Reset is synchronous: pool emptied, depth 65535, pool_size 4096.
`default_nettype none
module elliptic_arc_to_segments (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic signed [15:0] in_box_x,
  input  wire logic signed [15:0] in_box_y,
  input  wire logic [14:0]        in_box_width,
  input  wire logic [14:0]        in_box_height,
  input  wire logic signed [16:0] in_start_angle,
  input  wire logic signed [16:0] in_extent_angle,
  input  wire logic [15:0]        in_pen_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_seg_x_start,
  output logic signed [16:0]      out_seg_y_start,
  output logic signed [16:0]      out_seg_x_end,
  output logic signed [16:0]      out_seg_y_end,
  output logic [15:0]             out_seg_color,
  output logic [15:0]             out_seg_depth,
  output logic                    out_seg_last,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import eats_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_wr;
  logic [15:0] pool_size;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_POOL_SIZE);
  assign cfg_prdata = (cfg_paddr == ADDR_POOL_SIZE) ? {16'd0, pool_size} : 32'd0;

  eats_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eats_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr          (cfg_wr),
    .cfg_data        (cfg_pwdata[15:0]),
    .pool_size       (pool_size),
    .in_req_type     (in_req_type),
    .in_box_x        (in_box_x),
    .in_box_y        (in_box_y),
    .in_box_width    (in_box_width),
    .in_box_height   (in_box_height),
    .in_start_angle  (in_start_angle),
    .in_extent_angle (in_extent_angle),
    .in_pen_color    (in_pen_color),
    .out_seg_x_start (out_seg_x_start),
    .out_seg_y_start (out_seg_y_start),
    .out_seg_x_end   (out_seg_x_end),
    .out_seg_y_end   (out_seg_y_end),
    .out_seg_color   (out_seg_color),
    .out_seg_depth   (out_seg_depth),
    .out_seg_last    (out_seg_last)
  );

endmodule
`default_nettype wire
